/* rtl/kptq_pkg.sv */
// Package for the keyed priority task queue: sizes, action and status codes.
// No dependencies.
`default_nettype none
package kptq_pkg;
  localparam int unsigned Capacity = 64;
  localparam int unsigned KeyBits = 16;
  localparam int unsigned PrioBits = 32;
  localparam int unsigned OwnerBits = 16;
  localparam int unsigned IdxBits = $clog2(Capacity);
  localparam int unsigned CntBits = $clog2(Capacity + 1);

  typedef enum logic [1:0] {
    ACT_ADD = 2'd0,
    ACT_CHANGE = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_POP = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_ABSENT = 2'd1,
    ST_FULL = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_APPLY,
    FSM_OUT
  } fsm_e;

  // Data that circulates through the chain of cells, one entry per cell.
  typedef struct packed {
    logic                 valid;
    logic [KeyBits-1:0]   key;
    logic [OwnerBits-1:0] owner;
    logic [PrioBits-1:0]  prio;
  } entry_t;

  // Command from the controller to every cell.
  typedef struct packed {
    logic        shift;
    logic        write_head;
    entry_t      head_data;
  } chain_ctrl_t;
endpackage
`default_nettype wire

/* rtl/kptq_cell.sv */
// One storage cell of the task ring: holds one entry and passes it on when shifted.
// Depends on kptq_pkg.
`default_nettype none
module kptq_cell (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            shift_i,
  input  wire kptq_pkg::entry_t prev_i,
  output kptq_pkg::entry_t     entry_o
);
  import kptq_pkg::*;

  logic   valid_q;
  entry_t data_q;

  // The valid flag is control state and is cleared by reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (shift_i) begin
      valid_q <= prev_i.valid;
    end
  end

  // Payload moves along with the flag.
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      data_q <= prev_i;
    end
  end

  always_comb begin
    entry_o = data_q;
    entry_o.valid = valid_q;
  end
endmodule
`default_nettype wire

/* rtl/kptq_ring.sv */
// Ring of storage cells that rotates one place per shift cycle.
// Depends on kptq_pkg and kptq_cell.
`default_nettype none
module kptq_ring (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire kptq_pkg::chain_ctrl_t ctrl_i,
  output kptq_pkg::entry_t        tail_o
);
  import kptq_pkg::*;

  entry_t cell_out [Capacity];
  entry_t cell_in  [Capacity];

  // The tail entry re-enters at the head unless the controller replaces it.
  always_comb begin
    cell_in[0] = ctrl_i.write_head ? ctrl_i.head_data : cell_out[Capacity-1];
    for (int i = 1; i < Capacity; i++) begin
      cell_in[i] = cell_out[i-1];
    end
  end

  for (genvar g = 0; g < Capacity; g++) begin : g_cell
    kptq_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (ctrl_i.shift),
      .prev_i  (cell_in[g]),
      .entry_o (cell_out[g])
    );
  end

  assign tail_o = cell_out[Capacity-1];
endmodule
`default_nettype wire

/* rtl/keyed_priority_task_queue_top.sv */
// Keyed priority task queue: 64 tasks held in a rotating chain of cells.
// Each transaction makes a search rotation, a turnaround state, an apply rotation and an
// output state that registers the result; only then is the next transaction taken, so the
// queue handles one transaction at a time. A result still waiting on the output holds the
// next one back. The ring turns one position per cycle while scanning.
// Reset clears all valid flags (empty table) and the output valid flag at once.
`default_nettype none
module keyed_priority_task_queue_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  action_i,
  input  wire logic [15:0] owner_id_i,
  input  wire logic [15:0] task_key_i,
  input  wire logic [31:0] task_priority_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [15:0]      popped_owner_o,
  output logic [1:0]       status_o
);
  import kptq_pkg::*;

  fsm_e state_q, state_d;
  logic pass_q, pass_d;                 // 0: search rotation, 1: apply rotation
  logic [IdxBits-1:0] pos_q, pos_d;     // position index of entry at tail
  action_e act_q;
  logic [OwnerBits-1:0] own_q;
  logic [KeyBits-1:0] key_q;
  logic [PrioBits-1:0] prio_q;
  logic match_hit_q, match_hit_d, free_hit_q, free_hit_d, best_hit_q, best_hit_d;
  logic [IdxBits-1:0] match_q, match_d, free_q, free_d, best_q, best_d;
  logic [PrioBits-1:0] best_prio_q, best_prio_d;
  logic [KeyBits-1:0] best_key_q, best_key_d;
  logic [OwnerBits-1:0] best_own_q, best_own_d;
  logic [OwnerBits-1:0] res_own_q, res_own_d;
  status_e res_st_q, res_st_d;
  logic out_valid_q, out_valid_d;

  chain_ctrl_t ctrl;
  entry_t tail;
  logic last;

  kptq_ring u_ring (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .tail_o (tail)
  );

  // Tail index counts up from zero so that the lowest slot is seen first in each pass.
  // Cell k holds slot (Capacity-1-k) at rest; the tail shows slots from 0 upward.
  assign last = (pos_q == IdxBits'(Capacity - 1));

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FSM_IDLE:  if (in_valid_i) state_d = FSM_SCAN;
      FSM_SCAN:  if (last && pass_q) state_d = FSM_OUT;
                 else if (last) state_d = FSM_APPLY;
      FSM_APPLY: state_d = FSM_SCAN;
      FSM_OUT:   if (!out_valid_q || out_ready_i) state_d = FSM_IDLE;
      default:   state_d = FSM_IDLE;
    endcase
  end

  // Search accumulators: key match, first free slot, best entry.
  always_comb begin
    match_hit_d = match_hit_q;
    match_d     = match_q;
    free_hit_d  = free_hit_q;
    free_d      = free_q;
    best_hit_d  = best_hit_q;
    best_d      = best_q;
    best_prio_d = best_prio_q;
    best_key_d  = best_key_q;
    best_own_d  = best_own_q;
    if (state_q == FSM_IDLE) begin
      match_hit_d = 1'b0;
      free_hit_d  = 1'b0;
      best_hit_d  = 1'b0;
    end else if (state_q == FSM_SCAN && !pass_q) begin
      if (tail.valid && tail.key == key_q) begin
        match_hit_d = 1'b1;
        match_d     = pos_q;
      end
      if (!tail.valid && !free_hit_q) begin
        free_hit_d = 1'b1;
        free_d     = pos_q;
      end
      if (tail.valid && (!best_hit_q || tail.prio > best_prio_q ||
          (tail.prio == best_prio_q && tail.key > best_key_q))) begin
        best_hit_d  = 1'b1;
        best_d      = pos_q;
        best_prio_d = tail.prio;
        best_key_d  = tail.key;
        best_own_d  = tail.owner;
      end
    end
  end

  // Outcome of the search, loaded into the result registers once the output is free.
  always_comb begin
    res_own_d = res_own_q;
    res_st_d  = res_st_q;
    if (state_q == FSM_OUT && (!out_valid_q || out_ready_i)) begin
      res_own_d = '0;
      res_st_d  = ST_DONE;
      unique case (act_q) inside
        ACT_ADD:    if (!match_hit_q && !free_hit_q) res_st_d = ST_FULL;
        ACT_CHANGE, ACT_REMOVE: if (!match_hit_q) res_st_d = ST_ABSENT;
        ACT_POP:    if (!best_hit_q) res_st_d = ST_EMPTY;
                    else res_own_d = best_own_q;
        default:    res_st_d = ST_DONE;
      endcase
    end
  end

  // Ring control: rotate in scan, rewrite the target entry during the apply pass.
  always_comb begin
    ctrl.shift = (state_q == FSM_SCAN);
    ctrl.write_head = 1'b0;
    ctrl.head_data = tail;
    if (state_q == FSM_SCAN && pass_q) begin
      unique case (act_q)
        ACT_ADD: begin
          if ((match_hit_q && pos_q == match_q) ||
              (!match_hit_q && free_hit_q && pos_q == free_q)) begin
            ctrl.write_head = 1'b1;
            ctrl.head_data = '{valid: 1'b1, key: key_q, owner: own_q, prio: prio_q};
          end
        end
        ACT_CHANGE: begin
          if (match_hit_q && pos_q == match_q) begin
            ctrl.write_head = 1'b1;
            ctrl.head_data.prio = prio_q;
          end
        end
        ACT_REMOVE: begin
          if (match_hit_q && pos_q == match_q) begin
            ctrl.write_head = 1'b1;
            ctrl.head_data.valid = 1'b0;
          end
        end
        ACT_POP: begin
          if (best_hit_q && pos_q == best_q) begin
            ctrl.write_head = 1'b1;
            ctrl.head_data.valid = 1'b0;
          end
        end
        default: ctrl.write_head = 1'b0;
      endcase
    end
  end

  // Output and pass bookkeeping.
  always_comb begin
    pos_d       = (state_q == FSM_SCAN) ? pos_q + 1'b1 : '0;
    pass_d      = pass_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (state_q == FSM_IDLE) pass_d = 1'b0;
    if (state_q == FSM_APPLY) pass_d = 1'b1;
    if (state_q == FSM_OUT && (!out_valid_q || out_ready_i)) out_valid_d = 1'b1;
  end

  assign in_ready_o     = (state_q == FSM_IDLE);
  assign out_valid_o    = out_valid_q;
  assign popped_owner_o = res_own_q;
  assign status_o       = res_st_q;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      pass_q      <= 1'b0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
      match_hit_q <= 1'b0;
      free_hit_q  <= 1'b0;
      best_hit_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      pass_q      <= pass_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
      match_hit_q <= match_hit_d;
      free_hit_q  <= free_hit_d;
      best_hit_q  <= best_hit_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      act_q  <= action_e'(action_i);
      own_q  <= owner_id_i;
      key_q  <= task_key_i[KeyBits-1:0];
      prio_q <= task_priority_i[PrioBits-1:0];
    end
    match_q     <= match_d;
    free_q      <= free_d;
    best_q      <= best_d;
    best_prio_q <= best_prio_d;
    best_key_q  <= best_key_d;
    best_own_q  <= best_own_d;
    res_own_q   <= res_own_d;
    res_st_q    <= res_st_d;
  end
endmodule
`default_nettype wire

/* rtl/kptq_checker.sv */
// Port-level checker for the keyed priority task queue, bound to the top level.
// Depends on kptq_pkg.
`default_nettype none
module kptq_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [15:0] popped_owner_o,
  input wire logic [1:0]  status_o
);
  import kptq_pkg::*;

  // A result that waits keeps its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) &&
    $stable(popped_owner_o))
    else $error("result changed while stalled");

  // Only a successful pop reports an owner.
  a_owner_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_DONE |-> popped_owner_o == '0)
    else $error("owner reported on failure");

  // No new item is taken in the cycle after one was accepted.
  a_one_at_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second transaction taken too early");

  // A result never appears right after acceptance.
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o |=> !out_valid_o)
    else $error("result came too early");
endmodule

bind keyed_priority_task_queue_top kptq_checker u_kptq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .popped_owner_o (popped_owner_o),
  .status_o       (status_o)
);
`default_nettype wire

/* tb/sv/testbench.sv */
// Testbench for keyed_priority_task_queue_top: directed and random add, change,
// remove and pop transactions checked against a behavioural task table.
// Depends on kptq_pkg and the RTL of the task queue.
`timescale 1ns / 1ps
module testbench;
  import kptq_pkg::*;

  typedef struct packed {
    action_e     act;
    logic [15:0] owner;
    logic [15:0] key;
    logic [31:0] prio;
  } request_t;

  typedef struct packed {
    logic [15:0] owner;
    status_e     status;
  } reply_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  action_i = '0;
  logic [15:0] owner_id_i = '0;
  logic [15:0] task_key_i = '0;
  logic [31:0] task_priority_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [15:0] popped_owner_o;
  logic [1:0]  status_o;

  keyed_priority_task_queue_top uut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .action_i, .owner_id_i,
    .task_key_i, .task_priority_i, .out_valid_o, .out_ready_i,
    .popped_owner_o, .status_o
  );

  always #2 clk_i = ~clk_i;

  // Shadow copy of the task table.
  logic        tbl_valid [Capacity];
  logic [15:0] tbl_key   [Capacity];
  logic [15:0] tbl_owner [Capacity];
  logic [31:0] tbl_prio  [Capacity];

  request_t pending_reqs[$];
  reply_t   expected_replies[$];
  int       errors = 0;
  bit       stim_done = 1'b0;
  bit       hold_sender = 1'b0;

  // Apply one request to the shadow table and return the reply it should give.
  function automatic reply_t apply_request(request_t r);
    reply_t rep;
    int slot;
    int best;
    rep.owner = '0;
    rep.status = ST_DONE;
    slot = -1;
    best = -1;
    if (r.act != ACT_POP) begin
      for (int i = 0; i < Capacity; i++) begin
        if (slot < 0 && tbl_valid[i] && tbl_key[i] == r.key) slot = i;
      end
    end
    case (r.act)
      ACT_ADD: begin
        for (int i = 0; i < Capacity; i++) begin
          if (slot < 0 && !tbl_valid[i]) slot = i;
        end
        if (slot < 0) begin
          rep.status = ST_FULL;
        end else begin
          tbl_valid[slot] = 1'b1;
          tbl_key[slot] = r.key;
          tbl_owner[slot] = r.owner;
          tbl_prio[slot] = r.prio;
        end
      end
      ACT_CHANGE: begin
        if (slot < 0) rep.status = ST_ABSENT;
        else tbl_prio[slot] = r.prio;
      end
      ACT_REMOVE: begin
        if (slot < 0) rep.status = ST_ABSENT;
        else tbl_valid[slot] = 1'b0;
      end
      default: begin
        for (int i = 0; i < Capacity; i++) begin
          if (tbl_valid[i] && (best < 0 || tbl_prio[i] > tbl_prio[best] ||
              (tbl_prio[i] == tbl_prio[best] && tbl_key[i] > tbl_key[best])))
            best = i;
        end
        if (best < 0) begin
          rep.status = ST_EMPTY;
        end else begin
          rep.owner = tbl_owner[best];
          tbl_valid[best] = 1'b0;
        end
      end
    endcase
    return rep;
  endfunction

  function automatic request_t make_req(action_e a, int unsigned own, int unsigned k,
                                        logic [31:0] p);
    request_t r;
    r.act = a;
    r.owner = own[15:0];
    r.key = k[15:0];
    r.prio = p;
    return r;
  endfunction

  // Random request; keys mostly from a small pool so that hits are common.
  function automatic request_t random_req(int unsigned fill_bias);
    request_t r;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < fill_bias) r.act = ACT_ADD;
    else if (pick < fill_bias + (100 - fill_bias) / 3) r.act = ACT_CHANGE;
    else if (pick < fill_bias + 2 * (100 - fill_bias) / 3) r.act = ACT_REMOVE;
    else r.act = ACT_POP;
    r.owner = 16'($urandom());
    if ($urandom_range(9) < 8) r.key = 16'($urandom_range(95));
    else r.key = 16'($urandom());
    case ($urandom_range(3))
      0: r.prio = $urandom_range(7);
      1: r.prio = 32'hffff_fff8 | $urandom_range(7);
      default: r.prio = $urandom();
    endcase
    return r;
  endfunction

  // Driver: bursts of transactions separated by random gaps, idle during reset.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        expected_replies.push_back(apply_request(pending_reqs.pop_front()));
      end
      if (!(in_valid_i && !in_ready_o)) begin
        if (gap_left > 0 || hold_sender || pending_reqs.size() == 0 ||
            (in_valid_i && in_ready_o && pending_reqs.size() == 0)) begin
          in_valid_i <= 1'b0;
          if (gap_left > 0) gap_left <= gap_left - 1;
        end else begin
          in_valid_i <= 1'b1;
          action_i <= pending_reqs[0].act;
          owner_id_i <= pending_reqs[0].owner;
          task_key_i <= pending_reqs[0].key;
          task_priority_i <= pending_reqs[0].prio;
          if (burst_left > 0) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= $urandom_range(12);
            gap_left <= ($urandom_range(3) == 0) ? 0 : $urandom_range(300);
          end
        end
      end
    end
  end

  // Monitor: checks each reply and stalls the output on its own pattern.
  int stall_phase = 0;
  always @(posedge clk_i) begin
    reply_t want;
    if (out_valid_o && out_ready_i) begin
      if (expected_replies.size() == 0) begin
        $display("%0t: reply with none expected: owner %0d status %0d",
                 $time, popped_owner_o, status_o);
        errors++;
      end else begin
        want = expected_replies.pop_front();
        if (popped_owner_o !== want.owner) begin
          $display("%0t: popped_owner expected %0d actual %0d",
                   $time, want.owner, popped_owner_o);
          errors++;
        end
        if (status_o !== want.status) begin
          $display("%0t: status expected %0d actual %0d",
                   $time, want.status, status_o);
          errors++;
        end
      end
    end
    stall_phase <= stall_phase + 1;
    if ((stall_phase / 1500) % 3 == 0) out_ready_i <= 1'b1;
    else out_ready_i <= ($urandom_range(3) != 0) && (stall_phase % 97 > 20);
  end

  initial begin
    for (int i = 0; i < Capacity; i++) tbl_valid[i] = 1'b0;
    // Directed part: empty pop, absent keys, extremes, ties, overwrite.
    pending_reqs.push_back(make_req(ACT_POP, 0, 0, 0));
    pending_reqs.push_back(make_req(ACT_CHANGE, 0, 5, 1));
    pending_reqs.push_back(make_req(ACT_REMOVE, 0, 5, 1));
    pending_reqs.push_back(make_req(ACT_ADD, 16'hffff, 16'hffff, 32'hffff_ffff));
    pending_reqs.push_back(make_req(ACT_ADD, 16'h0001, 16'h0000, 32'hffff_ffff));
    pending_reqs.push_back(make_req(ACT_ADD, 16'h0002, 16'h0007, 32'h0));
    pending_reqs.push_back(make_req(ACT_ADD, 16'h5555, 16'h0007, 32'haaaa_aaaa));
    pending_reqs.push_back(make_req(ACT_CHANGE, 0, 16'h0000, 32'h0));
    pending_reqs.push_back(make_req(ACT_POP, 0, 0, 0));
    pending_reqs.push_back(make_req(ACT_POP, 0, 0, 0));
    pending_reqs.push_back(make_req(ACT_REMOVE, 0, 16'h0000, 0));
    pending_reqs.push_back(make_req(ACT_POP, 0, 0, 0));
    pending_reqs.push_back(make_req(ACT_POP, 0, 0, 0));
    // Fill the table past capacity, then drain it.
    for (int i = 0; i < Capacity + 2; i++)
      pending_reqs.push_back(make_req(ACT_ADD, i + 100, i * 997, $urandom_range(3)));
    for (int i = 0; i < Capacity + 1; i++)
      pending_reqs.push_back(make_req(ACT_POP, 0, 0, 0));
    // Random part in phases that fill and drain the table.
    for (int i = 0; i < 970; i++)
      pending_reqs.push_back(random_req((i / 150) % 2 ? 25 : 60));
    // Hold the sender once until every reply has come back.
    wait (pending_reqs.size() < 500);
    hold_sender = 1'b1;
    wait (expected_replies.size() == 0 && !in_valid_i);
    hold_sender = 1'b0;
    wait (pending_reqs.size() == 0 && !in_valid_i);
    stim_done = 1'b1;
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (stim_done && expected_replies.size() == 0);
    repeat (300) @(posedge clk_i);
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end
endmodule

/* files.f */
rtl/kptq_pkg.sv
rtl/kptq_cell.sv
rtl/kptq_ring.sv
rtl/keyed_priority_task_queue_top.sv
rtl/kptq_checker.sv
tb/sv/testbench.sv
